// ===== rtl/core/hvn_pkg.sv =====
// Shared constants and the queued item type for the hashed value noise block.
`default_nettype none
package hvn_pkg;

	localparam int unsigned FRAC_BITS     = 16;
	localparam int unsigned OUT_FRAC_BITS = 30;

	localparam logic [63:0] MIX_K1 = 64'hbf58476d1ce4e5b9;
	localparam logic [63:0] MIX_K2 = 64'h94d049bb133111eb;
	localparam logic [63:0] OFF_X  = 64'h632be59bd9b4e019;
	localparam logic [63:0] OFF_Z  = 64'h8cb92baa3f3d8dd7;

	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW    = 2;

	// divider: bits resolved per stage, stage map of the front pipeline
	localparam int unsigned DIV_BITS     = 4;
	localparam int unsigned QUO_STAGES   = 32 / DIV_BITS;
	localparam int unsigned CORR_STAGE   = QUO_STAGES + 1;
	localparam int unsigned FRAC_STAGES  = FRAC_BITS / DIV_BITS;
	localparam int unsigned FRONT_STAGES = CORR_STAGE + FRAC_STAGES + 1;

	localparam int unsigned BACK_STAGES = 17;

	typedef struct packed {
		logic signed [31:0] cell_x;
		logic signed [31:0] cell_z;
		logic [15:0]        frac_x;
		logic [15:0]        frac_z;
		logic [63:0]        salt;
	} item_t;

endpackage
`default_nettype wire

// ===== rtl/core/hvn_mix.sv =====
// 64-bit avalanche mix, four pipeline stages with split 32x32 products.
`default_nettype none
module hvn_mix (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [63:0] v,
	output logic      [63:0] h
);

	logic [63:0] x1, x3;
	logic [63:0] ll_s1, ll_s3;
	logic [31:0] lh_s1, hl_s1, lh_s3, hl_s3;
	logic [63:0] sum_s2, sum_s4;

	assign x1 = v ^ (v >> 30);
	assign x3 = sum_s2 ^ (sum_s2 >> 27);
	assign h  = sum_s4 ^ (sum_s4 >> 31);

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1  <= 64'(x1[31:0]) * 64'(hvn_pkg::MIX_K1[31:0]);
			lh_s1  <= 32'(x1[31:0] * hvn_pkg::MIX_K1[63:32]);
			hl_s1  <= 32'(x1[63:32] * hvn_pkg::MIX_K1[31:0]);
			sum_s2 <= ll_s1 + {32'(lh_s1 + hl_s1), 32'b0};
			ll_s3  <= 64'(x3[31:0]) * 64'(hvn_pkg::MIX_K2[31:0]);
			lh_s3  <= 32'(x3[31:0] * hvn_pkg::MIX_K2[63:32]);
			hl_s3  <= 32'(x3[63:32] * hvn_pkg::MIX_K2[31:0]);
			sum_s4 <= ll_s3 + {32'(lh_s3 + hl_s3), 32'b0};
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hvn_front.sv =====
// Front pipeline: floor division of both coordinates into cell and Q0.16 fraction.
`default_nettype none
module hvn_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [31:0]    coord_x,
	input  wire logic [31:0]    coord_z,
	input  wire logic [15:0]    cell_scale,
	input  wire logic [63:0]    salt,
	input  wire logic           q_full,
	output logic                q_push,
	output hvn_pkg::item_t      q_item
);

	localparam int unsigned NS = hvn_pkg::FRONT_STAGES;

	typedef struct packed {
		logic [15:0]       dvs;
		logic [1:0]        neg;
		logic [1:0][15:0]  rem;
		logic [1:0][31:0]  dq;
		logic [1:0][31:0]  cidx;
		logic [63:0]       salt;
	} fst_t;

	// four restoring-division steps; returns {remainder, quotient bits}
	function automatic logic [19:0] div_step4(logic [15:0] r, logic [3:0] b, logic [15:0] d);
		logic [16:0] t;
		logic [15:0] rr;
		logic [3:0]  q;
		rr = r;
		q  = '0;
		for (int k = 3; k >= 0; k--) begin
			t = {rr, b[k]};
			if (t >= {1'b0, d}) begin
				rr   = 16'(t - {1'b0, d});
				q[k] = 1'b1;
			end else begin
				rr = t[15:0];
			end
		end
		return {rr, q};
	endfunction

	logic [NS-1:0] vld_q;
	fst_t          st_q [NS];
	fst_t          nxt  [NS];
	logic          en;

	assign en       = !(vld_q[NS-1] && q_full);
	assign in_ready = en;
	assign q_push   = vld_q[NS-1] && !q_full;

	always_comb begin
		logic [19:0] step;
		logic [31:0] cin [2];
		step      = '0;
		cin[0]    = coord_x;
		cin[1]    = coord_z;
		nxt[0]      = '0;
		nxt[0].dvs  = (cell_scale == 16'd0) ? 16'd1 : cell_scale;
		nxt[0].salt = salt;
		for (int l = 0; l < 2; l++) begin
			nxt[0].neg[l] = cin[l][31];
			nxt[0].dq[l]  = cin[l][31] ? ~cin[l] : cin[l];
		end
		for (int i = 1; i < NS; i++) begin
			nxt[i] = st_q[i-1];
			for (int l = 0; l < 2; l++) begin
				if (i == hvn_pkg::CORR_STAGE) begin
					nxt[i].cidx[l] = st_q[i-1].neg[l] ? ~st_q[i-1].dq[l] : st_q[i-1].dq[l];
					nxt[i].rem[l]  = st_q[i-1].neg[l] ?
						16'(st_q[i-1].dvs - 16'd1 - st_q[i-1].rem[l]) : st_q[i-1].rem[l];
					nxt[i].dq[l]   = '0;
				end else begin
					step = div_step4(st_q[i-1].rem[l],
						(i < hvn_pkg::CORR_STAGE) ? st_q[i-1].dq[l][31:28] : 4'b0,
						st_q[i-1].dvs);
					nxt[i].rem[l] = step[19:4];
					nxt[i].dq[l]  = {st_q[i-1].dq[l][27:0], step[3:0]};
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NS; i++) begin
				st_q[i] <= nxt[i];
			end
		end
	end

	assign q_item.cell_x = st_q[NS-1].cidx[0];
	assign q_item.cell_z = st_q[NS-1].cidx[1];
	assign q_item.frac_x = st_q[NS-1].dq[0][15:0];
	assign q_item.frac_z = st_q[NS-1].dq[1][15:0];
	assign q_item.salt   = st_q[NS-1].salt;

endmodule
`default_nettype wire

// ===== rtl/core/hvn_fifo.sv =====
// Four-entry queue between the front and back pipelines.
`default_nettype none
module hvn_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire hvn_pkg::item_t wdata,
	input  wire logic           pop,
	output hvn_pkg::item_t      rdata,
	output logic                full,
	output logic                empty
);

	hvn_pkg::item_t                mem_q [hvn_pkg::FIFO_DEPTH];
	logic [hvn_pkg::FIFO_AW-1:0]   wr_q, rd_q;
	logic [hvn_pkg::FIFO_AW:0]     cnt_q;

	assign full  = (cnt_q == (hvn_pkg::FIFO_AW+1)'(hvn_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

// ===== rtl/core/hvn_back.sv =====
// Back pipeline: fade curves, corner hashing and bilinear blend.
`default_nettype none
module hvn_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire hvn_pkg::item_t head,
	input  wire logic           empty,
	output logic                pop,
	input  wire logic [63:0]    mixed_seed,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [30:0]         out_value
);

	localparam int unsigned NB = hvn_pkg::BACK_STAGES;
	localparam logic [63:0] OFF_X1 = hvn_pkg::OFF_X + 64'd1;
	localparam logic [63:0] OFF_Z1 = hvn_pkg::OFF_Z + 64'd1;
	localparam logic [20:0] TEN_ONE = 21'(10 << hvn_pkg::FRAC_BITS);
	localparam logic [16:0] ONE = 17'(1 << hvn_pkg::FRAC_BITS);
	localparam logic signed [31:0] CRN_OFS = 32'(1 << hvn_pkg::OUT_FRAC_BITS);

	logic [NB:1] vld_q;
	logic        en;

	assign en        = !vld_q[NB] || out_ready;
	assign pop       = en && !empty;
	assign out_valid = vld_q[NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NB-1:1], !empty};
		end
	end

	// stage 1: lattice keys
	logic [63:0] cx64, cz64;
	logic [63:0] kx0_s1, kx1_s1, kz0_s1, kz1_s1, salt_s1;
	logic [15:0] f_s1 [2];
	assign cx64 = {{32{head.cell_x[31]}}, head.cell_x};
	assign cz64 = {{32{head.cell_z[31]}}, head.cell_z};

	// fade lanes
	logic [31:0] sq_s2 [2];
	logic [15:0] f_s2 [2], f_s3 [2], f_s4 [2], f_s5 [2];
	logic [20:0] p_s3 [2], g1_s4 [2], g2_s5 [2];
	logic [16:0] t_s6 [2], t_s7 [2], t_s8 [2], t_s9 [2], t_s10 [2], t_s11 [2], t_s12 [2];
	logic [20:0] p_nx [2], g1_nx [2], g2_nx [2], g3_nx [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			p_nx[l]  = 21'(21'd6 * {5'b0, sq_s2[l][31:16]}) + TEN_ONE
				- 21'(21'd15 * {5'b0, f_s2[l]});
			g1_nx[l] = 21'(({21'b0, f_s3[l]} * {16'b0, p_s3[l]}) >> hvn_pkg::FRAC_BITS);
			g2_nx[l] = 21'(({21'b0, f_s4[l]} * {16'b0, g1_s4[l]}) >> hvn_pkg::FRAC_BITS);
			g3_nx[l] = 21'(({21'b0, f_s5[l]} * {16'b0, g2_s5[l]}) >> hvn_pkg::FRAC_BITS);
		end
	end

	// coordinate mixes (stages 2..5)
	logic [63:0] hx0, hx1, hz0, hz1;
	hvn_mix u_mx0 (.clk(clk), .en(en), .v(kx0_s1), .h(hx0));
	hvn_mix u_mx1 (.clk(clk), .en(en), .v(kx1_s1), .h(hx1));
	hvn_mix u_mz0 (.clk(clk), .en(en), .v(kz0_s1), .h(hz0));
	hvn_mix u_mz1 (.clk(clk), .en(en), .v(kz1_s1), .h(hz1));

	logic [63:0] salt_s2, salt_s3, salt_s4, salt_s5;
	logic [63:0] key_s6 [4];
	logic [63:0] hc [4];

	// corner mixes (stages 7..10): a, b, c, d
	hvn_mix u_mc0 (.clk(clk), .en(en), .v(key_s6[0]), .h(hc[0]));
	hvn_mix u_mc1 (.clk(clk), .en(en), .v(key_s6[1]), .h(hc[1]));
	hvn_mix u_mc2 (.clk(clk), .en(en), .v(key_s6[2]), .h(hc[2]));
	hvn_mix u_mc3 (.clk(clk), .en(en), .v(key_s6[3]), .h(hc[3]));

	// blend
	logic signed [31:0] crn_s11 [4];
	logic signed [32:0] dab_s12, dcd_s12;
	logic signed [31:0] a_s12, c_s12, a_s13, c_s13;
	logic signed [50:0] pab_s13, pcd_s13;
	logic signed [17:0] tx_e, tz_e;
	logic [16:0]        tz_s13, tz_s14, tz_s15;
	logic signed [32:0] front_s14, back_s14, front_s15, front_s16;
	logic signed [33:0] dfb_s15;
	logic signed [51:0] p_s16;
	logic [30:0]        res_s17;

	assign tx_e = {1'b0, t_s12[0]};
	assign tz_e = {1'b0, tz_s15};
	assign out_value = res_s17;

	always_ff @(posedge clk) begin
		if (en) begin
			kx0_s1  <= cx64 + hvn_pkg::OFF_X;
			kx1_s1  <= cx64 + OFF_X1;
			kz0_s1  <= cz64 + hvn_pkg::OFF_Z;
			kz1_s1  <= cz64 + OFF_Z1;
			salt_s1 <= head.salt;
			f_s1[0] <= head.frac_x;
			f_s1[1] <= head.frac_z;
			for (int l = 0; l < 2; l++) begin
				sq_s2[l] <= 32'(f_s1[l]) * 32'(f_s1[l]);
				f_s2[l]  <= f_s1[l];
				p_s3[l]  <= p_nx[l];
				f_s3[l]  <= f_s2[l];
				g1_s4[l] <= g1_nx[l];
				f_s4[l]  <= f_s3[l];
				g2_s5[l] <= g2_nx[l];
				f_s5[l]  <= f_s4[l];
				t_s6[l]  <= (g3_nx[l] > 21'(ONE)) ? ONE : g3_nx[l][16:0];
				t_s7[l]  <= t_s6[l];
				t_s8[l]  <= t_s7[l];
				t_s9[l]  <= t_s8[l];
				t_s10[l] <= t_s9[l];
				t_s11[l] <= t_s10[l];
				t_s12[l] <= t_s11[l];
			end
			salt_s2 <= salt_s1;
			salt_s3 <= salt_s2;
			salt_s4 <= salt_s3;
			salt_s5 <= salt_s4;
			key_s6[0] <= mixed_seed ^ salt_s5 ^ hx0 ^ hz0;
			key_s6[1] <= mixed_seed ^ salt_s5 ^ hx1 ^ hz0;
			key_s6[2] <= mixed_seed ^ salt_s5 ^ hx0 ^ hz1;
			key_s6[3] <= mixed_seed ^ salt_s5 ^ hx1 ^ hz1;
			for (int i = 0; i < 4; i++) begin
				crn_s11[i] <= $signed({1'b0, hc[i][63:33]}) - CRN_OFS;
			end
			dab_s12   <= 33'(crn_s11[1]) - 33'(crn_s11[0]);
			dcd_s12   <= 33'(crn_s11[3]) - 33'(crn_s11[2]);
			a_s12     <= crn_s11[0];
			c_s12     <= crn_s11[2];
			pab_s13   <= 51'(dab_s12) * 51'(tx_e);
			pcd_s13   <= 51'(dcd_s12) * 51'(tx_e);
			a_s13     <= a_s12;
			c_s13     <= c_s12;
			tz_s13    <= t_s12[1];
			front_s14 <= 33'(51'(a_s13) + (pab_s13 >>> hvn_pkg::FRAC_BITS));
			back_s14  <= 33'(51'(c_s13) + (pcd_s13 >>> hvn_pkg::FRAC_BITS));
			tz_s14    <= tz_s13;
			dfb_s15   <= 34'(back_s14) - 34'(front_s14);
			front_s15 <= front_s14;
			tz_s15    <= tz_s14;
			p_s16     <= 52'(dfb_s15) * 52'(tz_e);
			front_s16 <= front_s15;
			res_s17   <= 31'(52'(front_s16) + (p_s16 >>> hvn_pkg::FRAC_BITS));
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/hashed_value_noise_2d.sv =====
// Top level of the 2D hashed value noise generator.
//
// Input stream s_axis: one item holds coord_x, coord_z (signed 32), cell_scale
// (16, zero acts as one) and a 64-bit salt. Output stream m_axis: one item per
// input item, the Q1.30 noise value in tdata[30:0], in input order.
// APB register 0 (address 0) holds the signed world seed; its mixed form goes
// through the seed mix pipeline after a write, so write it only while the block is idle.
// Throughput: one item per cycle while m_axis_tready stays high. The front
// divider pipeline (14 stages) feeds a four-entry queue that feeds the back
// pipeline (17 stages: hash mixes, fade curves, blend). Each pipeline stalls
// on its own: the back part holds while m_axis_tready is low, the queue
// fills, and then s_axis_tready drops.
// Reset clears all valid state and the seed register (seed 0).
`default_nettype none
module hashed_value_noise_2d (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// coord_x[31:0], coord_z[63:32], cell_scale[79:64], salt[143:80]
	input  wire logic [143:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// noise_value[30:0], zero [31]
	output logic [31:0]       m_axis_tdata,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [31:0]    world_seed_q;
	logic [63:0]    mixed_seed;
	logic           q_full, q_empty, q_push, q_pop;
	hvn_pkg::item_t q_wdata, q_rdata;
	logic [30:0]    noise_value;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? world_seed_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_seed_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			world_seed_q <= pwdata;
		end
	end

	hvn_mix u_seed_mix (
		.clk(clk),
		.en (1'b1),
		.v  ({{32{world_seed_q[31]}}, world_seed_q}),
		.h  (mixed_seed)
	);

	hvn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.coord_x   (s_axis_tdata[31:0]),
		.coord_z   (s_axis_tdata[63:32]),
		.cell_scale(s_axis_tdata[79:64]),
		.salt      (s_axis_tdata[143:80]),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_wdata)
	);

	hvn_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty)
	);

	hvn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_rdata),
		.empty     (q_empty),
		.pop       (q_pop),
		.mixed_seed(mixed_seed),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_value (noise_value)
	);

	assign m_axis_tdata = {1'b0, noise_value};

endmodule
`default_nettype wire
